// File: rtl/sha1_pkg.sv
package sha1_pkg;

    localparam int WORD_W      = 32;
    localparam int CHAIN_WORDS = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int BLOCK_BITS  = BLOCK_WORDS * WORD_W;
    localparam int ROUNDS      = 80;
    localparam int ROUND_W     = $clog2(ROUNDS);

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] ROUND_F2   = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] ROUND_F3   = ROUND_W'(40);
    localparam logic [ROUND_W-1:0] ROUND_F4   = ROUND_W'(60);

    localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Byte position at which the 64-bit length field starts.
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [2:0] LEN_LAST = 3'd7;
    localparam logic [2:0] IDX_LAST = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_PAD80,
        S_ZERO,
        S_LEN,
        S_OUT
    } top_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } core_state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       start;
        logic       reinit;
        logic [2:0] word_idx;
    } core_ctrl_t;

    typedef struct packed {
        logic        done;
        logic [31:0] word;
    } core_stat_t;

endpackage

// File: rtl/sha1_in_if.sv
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;

    modport source (output valid, output data_byte, output byte_valid, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input last_byte,
                    output ready);
endinterface

// File: rtl/sha1_out_if.sv
interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

// File: rtl/sha1_core.sv
module sha1_core
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_ctrl_t ctrl,
    output core_stat_t stat
);

    core_state_t state_reg, state_next;

    logic [ROUND_W-1:0]    round_reg, round_next;
    logic [BLOCK_BITS-1:0] msg_reg, msg_next;
    logic [31:0]           chain_reg [CHAIN_WORDS];
    logic [31:0]           chain_next [CHAIN_WORDS];
    logic [31:0]           a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]           a_next, b_next, c_next, d_next, e_next;

    logic [31:0] w_cur, w_new, f_val, k_val, temp;

    // The message register doubles as the schedule: word 0 sits in the top bits and
    // each round shifts one word out and the next expanded word in at the bottom.
    assign w_cur = msg_reg[BLOCK_BITS-1 -: WORD_W];

    always_comb
    begin
        logic [31:0] x;
        x = msg_reg[BLOCK_BITS-1-13*WORD_W -: WORD_W] ^ msg_reg[BLOCK_BITS-1-8*WORD_W -: WORD_W]
          ^ msg_reg[BLOCK_BITS-1-2*WORD_W -: WORD_W] ^ w_cur;
        w_new = {x[30:0], x[31]};
    end

    always_comb
    begin
        if (round_reg < ROUND_F2)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (round_reg < ROUND_F3)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (round_reg < ROUND_F4)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
    end

    assign temp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        round_next = round_reg;
        msg_next   = msg_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        stat.done  = 1'b0;
        stat.word  = chain_reg[ctrl.word_idx];
        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.push)
                begin
                    msg_next = {msg_reg[BLOCK_BITS-9:0], ctrl.push_byte};
                end
                if (ctrl.start)
                begin
                    round_next = '0;
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                    e_next     = chain_reg[4];
                end
                if (ctrl.reinit)
                begin
                    chain_next = H_INIT;
                end
            end
            C_ROUND:
            begin
                msg_next   = {msg_reg[BLOCK_BITS-WORD_W-1:0], w_new};
                round_next = round_reg + 1'b1;
                a_next     = temp;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
            end
            C_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                stat.done     = 1'b1;
            end
            default:
            begin
                stat.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            chain_reg <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule

// File: rtl/sha1_message_digest.sv
// SHA-1 digest of a byte stream. Each request on msg carries at most one message byte;
// last_byte closes the message, and a request with last_byte but no byte ends the message
// as it stands (with nothing before it, the empty message). A byte is taken whenever msg
// is ready. Every 64th byte starts the compression, which runs one round per cycle on a
// single shared round unit: 80 rounds and then the chaining add, during which msg is not
// ready. After the last request the block feeds the padding through the same byte path,
// one byte per cycle outside compressions (0x80, zero fill to byte 56, the 64-bit
// big-endian bit length), compresses the final one or two blocks, and then offers the five
// digest words on digest, h0 first, word_index 0 to 4, with last_word on the fifth. After
// the fifth word is taken the block is ready for the next message. Over long messages each
// 64-byte block costs its byte transfers plus one compression; a message end adds the
// padding bytes, one or two compressions and the five output transfers.
module sha1_message_digest
    import sha1_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sha1_in_if.sink         msg,
    sha1_out_if.source      digest
);

    top_state_t state_reg, state_next;
    top_state_t ret_reg, ret_next;

    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [2:0]  len_cnt_reg, len_cnt_next;
    logic [2:0]  idx_reg, idx_next;

    core_ctrl_t ctrl;
    core_stat_t stat;

    logic in_fire, out_fire, wrap;

    sha1_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    assign in_fire  = msg.valid && msg.ready;
    assign out_fire = digest.valid && digest.ready;
    assign wrap     = ctrl.push && (pos_reg == LAST_POS);

    // Outputs and core control.
    always_comb
    begin
        msg.ready      = 1'b0;
        digest.valid   = 1'b0;
        ctrl.push      = 1'b0;
        ctrl.push_byte = ZERO_BYTE;
        ctrl.reinit    = 1'b0;
        ctrl.word_idx  = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                msg.ready      = 1'b1;
                ctrl.push      = msg.valid && msg.byte_valid;
                ctrl.push_byte = msg.data_byte;
            end
            S_PAD80:
            begin
                ctrl.push      = 1'b1;
                ctrl.push_byte = PAD_BYTE;
            end
            S_ZERO:
            begin
                ctrl.push      = (pos_reg != LEN_POS);
                ctrl.push_byte = ZERO_BYTE;
            end
            S_LEN:
            begin
                ctrl.push      = 1'b1;
                ctrl.push_byte = bit_count_reg[63:56];
            end
            S_OUT:
            begin
                digest.valid = 1'b1;
                ctrl.reinit  = digest.ready && (idx_reg == IDX_LAST);
            end
            default:
            begin
                msg.ready = 1'b0;
            end
        endcase
        ctrl.start = ctrl.push && (pos_reg == LAST_POS);
    end

    assign digest.digest_word = stat.word;
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == IDX_LAST);

    // Next state and counters.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        len_cnt_next   = len_cnt_reg;
        idx_next       = idx_reg;
        bit_count_next = bit_count_reg;
        pos_next       = ctrl.push ? pos_reg + 1'b1 : pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (msg.byte_valid)
                    begin
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    if (wrap)
                    begin
                        state_next = S_ROUND;
                        ret_next   = msg.last_byte ? S_PAD80 : S_IDLE;
                    end
                    else if (msg.last_byte)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_ROUND:
            begin
                if (stat.done)
                begin
                    state_next = ret_reg;
                end
            end
            S_PAD80:
            begin
                state_next = wrap ? S_ROUND : S_ZERO;
                ret_next   = S_ZERO;
            end
            S_ZERO:
            begin
                if (pos_reg == LEN_POS)
                begin
                    state_next   = S_LEN;
                    len_cnt_next = '0;
                end
                else if (wrap)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_ZERO;
                end
            end
            S_LEN:
            begin
                // The length bytes leave the counter most significant first.
                bit_count_next = {bit_count_reg[55:0], ZERO_BYTE};
                len_cnt_next   = len_cnt_reg + 1'b1;
                if (len_cnt_reg == LEN_LAST)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_OUT;
                    idx_next   = '0;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next     = S_IDLE;
                        idx_next       = '0;
                        bit_count_next = '0;
                        pos_next       = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            pos_reg       <= '0;
            bit_count_reg <= '0;
            len_cnt_reg   <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pos_reg       <= pos_next;
            bit_count_reg <= bit_count_next;
            len_cnt_reg   <= len_cnt_next;
            idx_reg       <= idx_next;
        end
    end

endmodule
